/* rtl/core/mhpq_pkg.sv */
package mhpq_pkg;

    // Store size and key width.
    localparam int CAPACITY = 1024;
    localparam int KEY_BITS = 32;

    // A slot number runs from 1 to CAPACITY, a count from 0 to CAPACITY.
    localparam int IDX_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CH_W   = IDX_W + 1;

    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_EXTRACT  = 2'd1,
        OP_INCREASE = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_FULL      = 3'd2,
        ST_BAD_INDEX = 3'd3,
        ST_SMALLER   = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INC_W,
        S_UP,
        S_UP_W,
        S_EXT_W,
        S_DN,
        S_DN_L,
        S_DN_R,
        S_FIN
    } state_t;

    // Slots are 1-based, memory addresses start at zero.
    function automatic logic [ADDR_W-1:0] slot_addr(input logic [IDX_W-1:0] slot);
        logic [IDX_W-1:0] m;
        begin
            m = slot - IDX_W'(1);
            return m[ADDR_W-1:0];
        end
    endfunction

endpackage

/* rtl/core/mhpq_in_if.sv */
interface mhpq_in_if import mhpq_pkg::*; ();

    logic                       valid;
    logic                       ready;
    logic [1:0]                 op;
    logic signed [KEY_BITS-1:0] key;
    logic [IDX_W-1:0]           index;

    modport source (output valid, output op, output key, output index, input ready);
    modport sink   (input valid, input op, input key, input index, output ready);

endinterface

/* rtl/core/mhpq_out_if.sv */
interface mhpq_out_if import mhpq_pkg::*; ();

    logic                       valid;
    logic                       ready;
    logic [2:0]                 status;
    logic signed [KEY_BITS-1:0] extracted_key;
    logic signed [KEY_BITS-1:0] top_key;
    logic                       top_valid;
    logic [IDX_W-1:0]           entry_count;

    modport source (
        output valid, output status, output extracted_key, output top_key,
        output top_valid, output entry_count, input ready
    );
    modport sink (
        input valid, input status, input extracted_key, input top_key,
        input top_valid, input entry_count, output ready
    );

endinterface

/* rtl/core/max_heap_priority_queue.sv */
// Binary max-heap priority queue; one result beat for every request beat. An insert or an
// increase-key climbs from its slot towards the root one level at a time; an extract moves the
// last entry to the root and sinks it one level at a time; a rejected request or a smaller key
// leaves the heap alone. One item at a time; a request is taken while a result waits.
// Reset clears the entry count and the control state; the store itself is not cleared.
module max_heap_priority_queue import mhpq_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    mhpq_in_if.sink    request,
    mhpq_out_if.source response
);

    localparam logic [IDX_W-1:0] CAP_COUNT = IDX_W'(CAPACITY);
    localparam logic [IDX_W-1:0] ROOT_SLOT = IDX_W'(1);

    state_t                     state_reg, state_next;
    logic [IDX_W-1:0]           cnt_reg, cnt_next;
    logic [IDX_W-1:0]           slot_reg, slot_next;
    logic signed [KEY_BITS-1:0] val_reg, val_next;
    logic signed [KEY_BITS-1:0] key_reg, key_next;
    logic signed [KEY_BITS-1:0] cand_key_reg, cand_key_next;
    logic                       cand_left_reg, cand_left_next;
    logic signed [KEY_BITS-1:0] top_reg, top_next;
    logic signed [KEY_BITS-1:0] ext_reg, ext_next;
    status_t                    status_reg, status_next;

    status_t                    out_status_reg;
    logic signed [KEY_BITS-1:0] out_ext_reg;
    logic signed [KEY_BITS-1:0] out_top_reg;
    logic                       out_top_valid_reg;
    logic [IDX_W-1:0]           out_count_reg;
    logic                       out_valid_reg, out_valid_next;
    logic                       load_out;

    logic                       wr_en;
    logic [ADDR_W-1:0]          wr_addr;
    logic signed [KEY_BITS-1:0] wr_key;
    logic                       rd_en;
    logic [ADDR_W-1:0]          rd_addr;
    logic [KEY_BITS-1:0]        rd_data;
    logic signed [KEY_BITS-1:0] rd_key;

    logic                       dn_go;
    logic                       dn_move;
    logic [IDX_W-1:0]           dn_child;
    logic signed [KEY_BITS-1:0] dn_key;
    logic [CH_W-1:0]            left_ch;
    logic [CH_W-1:0]            right_ch;
    logic [CH_W-1:0]            next_left_ch;
    logic [CH_W-1:0]            cnt_ext;
    logic [IDX_W-1:0]           parent;

    // Key store.
    mhpq_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_key),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_key = $signed(rd_data);

    // Child and parent slots of the current position.
    assign left_ch      = {slot_reg, 1'b0};
    assign right_ch     = {slot_reg, 1'b1};
    assign next_left_ch = {dn_child, 1'b0};
    assign cnt_ext      = {1'b0, cnt_reg};
    assign parent       = slot_reg >> 1;

    // Sequencer: the moving key is held in val_reg and the vacant slot in slot_reg.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        slot_next      = slot_reg;
        val_next       = val_reg;
        key_next       = key_reg;
        cand_key_next  = cand_key_reg;
        cand_left_next = cand_left_reg;
        ext_next       = ext_reg;
        status_next    = status_reg;
        wr_en          = 1'b0;
        wr_addr        = slot_addr(slot_reg);
        wr_key         = val_reg;
        rd_en          = 1'b0;
        rd_addr        = slot_addr(slot_reg);
        load_out       = 1'b0;
        dn_go          = 1'b0;
        dn_move        = 1'b0;
        dn_child       = left_ch[IDX_W-1:0];
        dn_key         = rd_key;

        case (state_reg)
            S_IDLE:
            begin
                if (request.valid)
                begin
                    status_next = ST_OK;
                    ext_next    = '0;
                    key_next    = request.key;
                    case (op_t'(request.op))
                        OP_INSERT:
                        begin
                            if (cnt_reg == CAP_COUNT)
                            begin
                                status_next = ST_FULL;
                                state_next  = S_FIN;
                            end
                            else
                            begin
                                cnt_next   = cnt_reg + IDX_W'(1);
                                slot_next  = cnt_reg + IDX_W'(1);
                                val_next   = request.key;
                                state_next = S_UP;
                            end
                        end
                        OP_EXTRACT:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_FIN;
                            end
                            else
                            begin
                                ext_next   = top_reg;
                                rd_en      = 1'b1;
                                rd_addr    = slot_addr(cnt_reg);
                                cnt_next   = cnt_reg - IDX_W'(1);
                                state_next = S_EXT_W;
                            end
                        end
                        OP_INCREASE:
                        begin
                            if (request.index == '0 || request.index > cnt_reg)
                            begin
                                status_next = ST_BAD_INDEX;
                                state_next  = S_FIN;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = slot_addr(request.index);
                                slot_next  = request.index;
                                state_next = S_INC_W;
                            end
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end

            // The old key at the slot is back; a smaller new key leaves the heap alone.
            S_INC_W:
            begin
                if (rd_key > key_reg)
                begin
                    status_next = ST_SMALLER;
                    state_next  = S_FIN;
                end
                else
                begin
                    val_next   = key_reg;
                    state_next = S_UP;
                end
            end

            // Start of a climb: the root takes the key at once, otherwise fetch the parent.
            S_UP:
            begin
                if (slot_reg == ROOT_SLOT)
                begin
                    wr_en      = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = slot_addr(parent);
                    state_next = S_UP_W;
                end
            end

            // A smaller parent moves down, any next parent is fetched; else the key settles.
            S_UP_W:
            begin
                wr_en = 1'b1;
                if (val_reg > rd_key)
                begin
                    wr_key    = rd_key;
                    slot_next = parent;
                    if (parent == ROOT_SLOT)
                    begin
                        state_next = S_UP;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = slot_addr(parent >> 1);
                    end
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            // The last entry is back and sinks from the root, unless the heap is now empty.
            S_EXT_W:
            begin
                val_next  = rd_key;
                slot_next = ROOT_SLOT;
                if (cnt_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_DN;
                end
            end

            // No child left: the moving key settles here; otherwise the left child is fetched.
            S_DN:
            begin
                if (left_ch > cnt_ext)
                begin
                    wr_en      = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = slot_addr(left_ch[IDX_W-1:0]);
                    state_next = S_DN_L;
                end
            end

            // The left child is back; fetch the right one if it exists.
            S_DN_L:
            begin
                if (right_ch <= cnt_ext)
                begin
                    cand_left_next = rd_key > val_reg;
                    cand_key_next  = (rd_key > val_reg) ? rd_key : val_reg;
                    rd_en          = 1'b1;
                    rd_addr        = slot_addr(right_ch[IDX_W-1:0]);
                    state_next     = S_DN_R;
                end
                else
                begin
                    dn_go    = 1'b1;
                    dn_move  = rd_key > val_reg;
                    dn_child = left_ch[IDX_W-1:0];
                    dn_key   = rd_key;
                end
            end

            // The right child wins only if strictly larger than the best so far.
            S_DN_R:
            begin
                dn_go = 1'b1;
                if (rd_key > cand_key_reg)
                begin
                    dn_move  = 1'b1;
                    dn_child = right_ch[IDX_W-1:0];
                    dn_key   = rd_key;
                end
                else
                begin
                    dn_move  = cand_left_reg;
                    dn_child = left_ch[IDX_W-1:0];
                    dn_key   = cand_key_reg;
                end
            end

            // Hold the result until the output register is free.
            S_FIN:
            begin
                if (!out_valid_reg || response.ready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // One step down: the larger child moves up, or the moving key settles.
        if (dn_go)
        begin
            wr_en = 1'b1;
            if (!dn_move)
            begin
                state_next = S_FIN;
            end
            else
            begin
                wr_key    = dn_key;
                slot_next = dn_child;
                if (next_left_ch <= cnt_ext)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = slot_addr(next_left_ch[IDX_W-1:0]);
                    state_next = S_DN_L;
                end
                else
                begin
                    state_next = S_DN;
                end
            end
        end
    end

    // The root key is mirrored from every write to the first slot.
    always_comb
    begin
        top_next = top_reg;
        if (wr_en && wr_addr == '0)
        begin
            top_next = wr_key;
        end
    end

    // Output register occupancy.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (response.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and result payload.
    always_ff @(posedge clk)
    begin
        slot_reg      <= slot_next;
        val_reg       <= val_next;
        key_reg       <= key_next;
        cand_key_reg  <= cand_key_next;
        cand_left_reg <= cand_left_next;
        top_reg       <= top_next;
        ext_reg       <= ext_next;
        status_reg    <= status_next;
        if (load_out)
        begin
            out_status_reg    <= status_reg;
            out_ext_reg       <= ext_reg;
            out_top_reg       <= (cnt_reg != '0) ? top_reg : '0;
            out_top_valid_reg <= cnt_reg != '0;
            out_count_reg     <= cnt_reg;
        end
    end

    assign request.ready          = state_reg == S_IDLE;
    assign response.valid         = out_valid_reg;
    assign response.status        = out_status_reg;
    assign response.extracted_key = out_ext_reg;
    assign response.top_key       = out_top_reg;
    assign response.top_valid     = out_top_valid_reg;
    assign response.entry_count   = out_count_reg;

endmodule

/* rtl/core/mhpq_ram.sv */
module mhpq_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port and one registered read port; the read data holds between reads.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sim/max_heap_priority_queue_tb.sv */
`timescale 1ns / 100ps

module max_heap_priority_queue_tb;
    import mhpq_pkg::*;

    // The op code that the block leaves unused and must ignore.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic signed [KEY_BITS-1:0] KEY_MAX = {1'b0, {(KEY_BITS-1){1'b1}}};
    localparam logic signed [KEY_BITS-1:0] KEY_MIN = {1'b1, {(KEY_BITS-1){1'b0}}};

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 40;
    localparam int PRINT_LIMIT     = 100;

    typedef struct {
        logic [1:0]                 op;
        logic signed [KEY_BITS-1:0] key;
        logic [IDX_W-1:0]           index;
    } heap_op_t;

    typedef struct {
        status_t                    status;
        logic signed [KEY_BITS-1:0] extracted_key;
        logic signed [KEY_BITS-1:0] top_key;
        logic                       top_valid;
        logic [IDX_W-1:0]           entry_count;
    } heap_reply_t;

    logic clk;
    logic rst_n;

    mhpq_in_if  req_if ();
    mhpq_out_if resp_if ();

    max_heap_priority_queue u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_if),
        .response (resp_if)
    );

    // Shadow heap that tracks every accepted beat.
    logic signed [KEY_BITS-1:0] heap_keys [1:CAPACITY];
    int                         heap_fill;

    heap_op_t    heap_ops_pending [$];
    heap_reply_t replies_due [$];
    heap_op_t    in_flight;

    int  gen_count;
    int  send_gap;
    int  send_quiet;
    int  recv_stall;
    int  recv_quiet;
    int  replies_checked;
    int  error_count;
    logic hold_off;

    // Clock with a 10 ns period.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic void swap_keys(int a, int b);
        logic signed [KEY_BITS-1:0] t;
        t = heap_keys[a];
        heap_keys[a] = heap_keys[b];
        heap_keys[b] = t;
    endfunction

    function automatic void heap_sift_up(int slot);
        int s;
        s = slot;
        while (s > 1 && heap_keys[s] > heap_keys[s / 2])
        begin
            swap_keys(s, s / 2);
            s = s / 2;
        end
    endfunction

    // The larger child wins; on a tie the left child is kept.
    function automatic void heap_sift_down(int slot);
        int s;
        int l;
        int r;
        int big;
        s = slot;
        forever
        begin
            l = 2 * s;
            r = 2 * s + 1;
            big = s;
            if (l <= heap_fill && heap_keys[l] > heap_keys[big])
                big = l;
            if (r <= heap_fill && heap_keys[r] > heap_keys[big])
                big = r;
            if (big == s)
                break;
            swap_keys(s, big);
            s = big;
        end
    endfunction

    // Applies one request to the shadow heap and works out its reply.
    function automatic heap_reply_t heap_apply(heap_op_t item);
        heap_reply_t rep;
        int          idx;
        rep.status        = ST_OK;
        rep.extracted_key = '0;
        idx               = item.index;
        if (item.op == OP_INSERT)
        begin
            if (heap_fill >= CAPACITY)
                rep.status = ST_FULL;
            else
            begin
                heap_fill++;
                heap_keys[heap_fill] = item.key;
                heap_sift_up(heap_fill);
            end
        end
        else if (item.op == OP_EXTRACT)
        begin
            if (heap_fill == 0)
                rep.status = ST_EMPTY;
            else
            begin
                rep.extracted_key = heap_keys[1];
                heap_keys[1] = heap_keys[heap_fill];
                heap_fill--;
                heap_sift_down(1);
            end
        end
        else if (item.op == OP_INCREASE)
        begin
            if (idx == 0 || idx > heap_fill)
                rep.status = ST_BAD_INDEX;
            else if (heap_keys[idx] > item.key)
                rep.status = ST_SMALLER;
            else
            begin
                heap_keys[idx] = item.key;
                heap_sift_up(idx);
            end
        end
        rep.top_key     = (heap_fill > 0) ? heap_keys[1] : '0;
        rep.top_valid   = (heap_fill > 0);
        rep.entry_count = heap_fill[IDX_W-1:0];
        return rep;
    endfunction

    // Mostly short gaps, a few long ones, and now and then a run with none.
    function automatic int pick_idle(inout int quiet);
        int r;
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            quiet = $urandom_range(20, 60);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [KEY_BITS-1:0] random_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            case ($urandom_range(0, 3))
                0: return KEY_MAX;
                1: return KEY_MIN;
                2: return '0;
                default: return '1;
            endcase
        end
        if (r < 40)
            return KEY_BITS'($signed($urandom_range(0, 16)) - 8);
        return KEY_BITS'($urandom);
    endfunction

    // Queues one request and keeps a rough count of the entries it leaves.
    task automatic push_op(logic [1:0] op, logic signed [KEY_BITS-1:0] key, int index);
        heap_op_t item;
        item.op    = op;
        item.key   = key;
        item.index = index[IDX_W-1:0];
        heap_ops_pending.push_back(item);
        if (op == OP_INSERT && gen_count < CAPACITY)
            gen_count++;
        else if (op == OP_EXTRACT && gen_count > 0)
            gen_count--;
    endtask

    // One random request; increases mostly aim at a live slot, often with a large key.
    task automatic push_random(int ins_pct, int ext_pct);
        int r;
        int idx;
        logic signed [KEY_BITS-1:0] k;
        r = $urandom_range(0, 99);
        if (r < ins_pct)
            push_op(OP_INSERT, random_key(), $urandom_range(0, CAPACITY));
        else if (r < ins_pct + ext_pct)
            push_op(OP_EXTRACT, random_key(), $urandom_range(0, CAPACITY));
        else if (r < ins_pct + ext_pct + 2)
            push_op(OP_UNUSED, random_key(), $urandom_range(0, CAPACITY));
        else
        begin
            if (gen_count > 0 && $urandom_range(0, 99) < 85)
                idx = $urandom_range(1, gen_count);
            else
                idx = $urandom_range(0, CAPACITY);
            if ($urandom_range(0, 99) < 45)
                k = KEY_BITS'($urandom_range(32'h4000_0000, 32'h7fff_ffff));
            else
                k = random_key();
            push_op(OP_INCREASE, k, idx);
        end
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("%0t: reply %0d: %s is %0d, expected %0d",
                     $time, replies_checked, what, got, want);
    endtask

    // Request side: offers queued beats, with random gaps between them.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
                replies_due.push_back(heap_apply(in_flight));
            if (!req_if.valid || req_if.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_if.valid <= 1'b0;
                end
                else if (heap_ops_pending.size() > 0)
                begin
                    in_flight = heap_ops_pending.pop_front();
                    req_if.op    <= in_flight.op;
                    req_if.key   <= in_flight.key;
                    req_if.index <= in_flight.index;
                    req_if.valid <= 1'b1;
                    send_gap = pick_idle(send_quiet);
                end
                else
                    req_if.valid <= 1'b0;
            end
        end
    end

    // Response side: checks each beat against the oldest expected reply.
    always @(posedge clk or negedge rst_n)
    begin
        heap_reply_t want;
        if (!rst_n)
        begin
            resp_if.ready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (resp_if.valid && resp_if.ready)
            begin
                if (replies_due.size() == 0)
                    report_mismatch("unexpected reply, entry_count",
                                    resp_if.entry_count, -1);
                else
                begin
                    want = replies_due.pop_front();
                    if (resp_if.status !== want.status)
                        report_mismatch("status", resp_if.status, want.status);
                    if (resp_if.extracted_key !== want.extracted_key)
                        report_mismatch("extracted_key", resp_if.extracted_key,
                                        want.extracted_key);
                    if (resp_if.top_key !== want.top_key)
                        report_mismatch("top_key", resp_if.top_key, want.top_key);
                    if (resp_if.top_valid !== want.top_valid)
                        report_mismatch("top_valid", resp_if.top_valid, want.top_valid);
                    if (resp_if.entry_count !== want.entry_count)
                        report_mismatch("entry_count", resp_if.entry_count,
                                        want.entry_count);
                end
                replies_checked <= replies_checked + 1;
                recv_stall = pick_idle(recv_quiet);
            end
            if (hold_off)
                resp_if.ready <= 1'b0;
            else if (recv_stall > 0)
            begin
                recv_stall--;
                resp_if.ready <= 1'b0;
            end
            else
                resp_if.ready <= 1'b1;
        end
    end

    // Long hold-off on the response side so that the request side backs up.
    initial
    begin
        while (replies_checked < 100)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Guard against a hang.
    initial
    begin
        #10_000_000;
        $display("** max_heap_priority_queue: FAILED **");
        $finish;
    end

    initial
    begin
        rst_n           = 1'b0;
        req_if.valid    = 1'b0;
        req_if.op       = OP_INSERT;
        req_if.key      = '0;
        req_if.index    = '0;
        resp_if.ready   = 1'b0;
        hold_off        = 1'b0;
        heap_fill       = 0;
        gen_count       = 0;
        send_quiet      = 0;
        recv_quiet      = 0;
        replies_checked = 0;
        error_count     = 0;

        // Directed part: empty heap, extreme keys, ties, bad slots and the unused op.
        push_op(OP_EXTRACT, KEY_MAX, 0);
        push_op(OP_INCREASE, KEY_MAX, 1);
        push_op(OP_INSERT, '0, 0);
        push_op(OP_INSERT, KEY_MAX, CAPACITY);
        push_op(OP_INSERT, KEY_MIN, 0);
        push_op(OP_INSERT, '1, 0);
        push_op(OP_INSERT, 5, 0);
        push_op(OP_INSERT, 5, 0);
        push_op(OP_UNUSED, KEY_MIN, CAPACITY);
        push_op(OP_INCREASE, KEY_MAX, 0);
        push_op(OP_INCREASE, KEY_MAX, CAPACITY);
        push_op(OP_INCREASE, KEY_MAX, 7);
        push_op(OP_INCREASE, KEY_MIN, 3);
        push_op(OP_INCREASE, KEY_MIN, 6);
        push_op(OP_INCREASE, KEY_MAX, 6);
        push_op(OP_INCREASE, 100, 2);
        repeat (7) push_op(OP_EXTRACT, '0, 0);
        push_op(OP_INSERT, KEY_MIN, 0);
        push_op(OP_EXTRACT, '0, 0);
        push_op(OP_EXTRACT, '0, 0);

        // Random part: a mixed stretch, a fill up to capacity with overflow,
        // then work around a full heap.
        repeat (120) push_random(45, 35);
        while (gen_count < CAPACITY)
            push_random(95, 0);
        repeat (3) push_op(OP_INSERT, random_key(), 0);
        repeat (150) push_random(30, 45);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (heap_ops_pending.size() != 0 || req_if.valid || replies_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("** max_heap_priority_queue: PASSED **");
        else
            $display("** max_heap_priority_queue: FAILED **");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/mhpq_pkg.sv
rtl/core/mhpq_in_if.sv
rtl/core/mhpq_out_if.sv
rtl/core/mhpq_ram.sv
rtl/core/max_heap_priority_queue.sv
sim/max_heap_priority_queue_tb.sv
